// ===== rtl/dmbms_pkg.sv =====
package dmbms_pkg;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_TARGET_WIDTH    = 3'd0;
  localparam logic [2:0] REG_TARGET_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_REFRESH_WANTED  = 3'd2;
  localparam logic [2:0] REG_WANTED_RATE_NUM = 3'd3;
  localparam logic [2:0] REG_WANTED_RATE_DEN = 3'd4;

  typedef struct packed {
    logic [15:0] mode_width;
    logic [15:0] mode_height;
    logic [31:0] mode_rate_num;
    logic [31:0] mode_rate_den;
    logic        verified;
    logic        last_mode;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [15:0] best_width;
    logic [15:0] best_height;
    logic [31:0] best_rate_num;
    logic [31:0] best_rate_den;
  } out_t;

  typedef struct packed {
    logic [15:0] target_width;
    logic [15:0] target_height;
    logic        refresh_wanted;
    logic [31:0] wanted_rate_num;
    logic [31:0] wanted_rate_den;
  } cfg_t;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] h;
    logic [31:0] n;
    logic [31:0] d;
  } mode_t;

  // Multiplier schedule, one product per step
  typedef enum logic [4:0] {
    ST_CWTH  = 5'd0,  ST_CAN   = 5'd1,  ST_CAD   = 5'd2,  ST_BWTH  = 5'd3,
    ST_BAN   = 5'd4,  ST_BAD   = 5'd5,  ST_CAREA = 5'd6,  ST_BAREA = 5'd7,
    ST_ASPC  = 5'd8,  ST_ASPB  = 5'd9,  ST_CNWD  = 5'd10, ST_CRN   = 5'd11,
    ST_CRD   = 5'd12, ST_BNWD  = 5'd13, ST_BRN   = 5'd14, ST_BRD   = 5'd15,
    ST_XC0   = 5'd16, ST_XC1   = 5'd17, ST_XC2   = 5'd18, ST_XC3   = 5'd19,
    ST_XB0   = 5'd20, ST_XB1   = 5'd21, ST_XB2   = 5'd22, ST_XB3   = 5'd23,
    ST_RC    = 5'd24, ST_RB    = 5'd25
  } step_e;

  typedef struct packed {
    logic  load;
    logic  calc;
    step_e step;
    logic  decide;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } stat_t;

endpackage

// ===== rtl/dmbms_ctrl.sv =====
module dmbms_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  dmbms_pkg::stat_t stat_i,
  output dmbms_pkg::cmd_t  cmd_o
);
  import dmbms_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_CALC   = 3'b010,
    S_DECIDE = 3'b100
  } state_e;

  state_e state_q, state_d;
  step_e  step_q, step_d;

  // Sequence one request through the shared multiplier
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    cmd_o.step  = step_q;
    in_stall_o  = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = ST_CWTH;
          state_d    = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        if (step_q == ST_RB) begin
          state_d = S_DECIDE;
        end else begin
          step_d = step_e'(step_q + 5'd1);
        end
      end
      S_DECIDE: begin
        // a last request holds while a previous result still waits at the output
        if (!(stat_i.last && stat_i.out_busy)) begin
          cmd_o.decide = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= ST_CWTH;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== rtl/dmbms_dp.sv =====
module dmbms_dp #(
  parameter int unsigned MAX_DIM = 16384
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dmbms_pkg::in_t   in_data_i,
  input  dmbms_pkg::cfg_t  cfg_i,
  input  dmbms_pkg::cmd_t  cmd_i,
  output dmbms_pkg::stat_t stat_o,
  output dmbms_pkg::out_t  res_o
);
  import dmbms_pkg::*;

  localparam logic [15:0] MaxDim = 16'(MAX_DIM);

  in_t   item_q;
  mode_t cov_q, sh_q, cand, held;
  logic  have_cov_q, have_sh_q;
  logic  is_cover, cand_ok;

  logic [31:0] cwth_q, bwth_q, can_q, cad_q, ban_q, bad_q, ca_q, ba_q;
  logic [63:0] aspc_q, aspb_q, cnwd_q, crn_q, crd_q, bnwd_q, brn_q, brd_q;
  logic [63:0] rc_q, rb_q;
  logic [127:0] xc_q, xb_q;

  logic [31:0] op_a, op_b;
  logic [63:0] prod;

  function automatic logic dim_ok(input logic [15:0] v);
    dim_ok = (v != 16'd0) && (v <= MaxDim);
  endfunction

  function automatic logic [31:0] adiff32(input logic [31:0] a, input logic [31:0] b);
    adiff32 = (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [63:0] adiff64(input logic [63:0] a, input logic [63:0] b);
    adiff64 = (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [16:0] adiff16(input logic [15:0] a, input logic [15:0] b);
    adiff16 = (a >= b) ? {1'b0, a - b} : {1'b0, b - a};
  endfunction

  // Classify the candidate and pick the held best it competes with
  always_comb begin
    cand.w   = item_q.mode_width;
    cand.h   = item_q.mode_height;
    cand.n   = item_q.mode_rate_num;
    cand.d   = item_q.mode_rate_den;
    is_cover = (cand.w >= cfg_i.target_width) && (cand.h >= cfg_i.target_height);
    held     = is_cover ? cov_q : sh_q;
    cand_ok  = item_q.verified && dim_ok(cand.w) && dim_ok(cand.h) &&
               (cand.n != 32'd0) && (cand.d != 32'd0);
  end

  // Select multiplier operands per step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.step)
      ST_CWTH:  begin op_a = 32'(cand.w);             op_b = 32'(cfg_i.target_height); end
      ST_CAN:   begin op_a = 32'(cfg_i.target_width); op_b = 32'(cand.h); end
      ST_CAD:   begin op_a = 32'(cand.h);             op_b = 32'(cfg_i.target_height); end
      ST_BWTH:  begin op_a = 32'(held.w);             op_b = 32'(cfg_i.target_height); end
      ST_BAN:   begin op_a = 32'(cfg_i.target_width); op_b = 32'(held.h); end
      ST_BAD:   begin op_a = 32'(held.h);             op_b = 32'(cfg_i.target_height); end
      ST_CAREA: begin op_a = 32'(cand.w);             op_b = 32'(cand.h); end
      ST_BAREA: begin op_a = 32'(held.w);             op_b = 32'(held.h); end
      ST_ASPC:  begin op_a = can_q;                   op_b = bad_q; end
      ST_ASPB:  begin op_a = ban_q;                   op_b = cad_q; end
      ST_CNWD:  begin op_a = cand.n;                  op_b = cfg_i.wanted_rate_den; end
      ST_CRN:   begin op_a = cfg_i.wanted_rate_num;   op_b = cand.d; end
      ST_CRD:   begin op_a = cand.d;                  op_b = cfg_i.wanted_rate_den; end
      ST_BNWD:  begin op_a = held.n;                  op_b = cfg_i.wanted_rate_den; end
      ST_BRN:   begin op_a = cfg_i.wanted_rate_num;   op_b = held.d; end
      ST_BRD:   begin op_a = held.d;                  op_b = cfg_i.wanted_rate_den; end
      ST_XC0:   begin op_a = crn_q[31:0];             op_b = brd_q[31:0]; end
      ST_XC1:   begin op_a = crn_q[31:0];             op_b = brd_q[63:32]; end
      ST_XC2:   begin op_a = crn_q[63:32];            op_b = brd_q[31:0]; end
      ST_XC3:   begin op_a = crn_q[63:32];            op_b = brd_q[63:32]; end
      ST_XB0:   begin op_a = brn_q[31:0];             op_b = crd_q[31:0]; end
      ST_XB1:   begin op_a = brn_q[31:0];             op_b = crd_q[63:32]; end
      ST_XB2:   begin op_a = brn_q[63:32];            op_b = crd_q[31:0]; end
      ST_XB3:   begin op_a = brn_q[63:32];            op_b = crd_q[63:32]; end
      ST_RC:    begin op_a = cand.n;                  op_b = held.d; end
      ST_RB:    begin op_a = held.n;                  op_b = cand.d; end
      default:  begin op_a = '0;                      op_b = '0; end
    endcase
  end

  assign prod = 64'(op_a) * 64'(op_b);

  // Store products, accumulate the wide refresh cross products
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.calc) begin
      case (cmd_i.step)
        ST_CWTH:  cwth_q <= prod[31:0];
        ST_CAN:   can_q  <= adiff32(cwth_q, prod[31:0]);
        ST_CAD:   cad_q  <= prod[31:0];
        ST_BWTH:  bwth_q <= prod[31:0];
        ST_BAN:   ban_q  <= adiff32(bwth_q, prod[31:0]);
        ST_BAD:   bad_q  <= prod[31:0];
        ST_CAREA: ca_q   <= prod[31:0];
        ST_BAREA: ba_q   <= prod[31:0];
        ST_ASPC:  aspc_q <= prod;
        ST_ASPB:  aspb_q <= prod;
        ST_CNWD:  cnwd_q <= prod;
        ST_CRN:   crn_q  <= adiff64(cnwd_q, prod);
        ST_CRD:   crd_q  <= prod;
        ST_BNWD:  bnwd_q <= prod;
        ST_BRN:   brn_q  <= adiff64(bnwd_q, prod);
        ST_BRD:   brd_q  <= prod;
        ST_XC0:   xc_q   <= {64'd0, prod};
        ST_XC1,
        ST_XC2:   xc_q   <= xc_q + {32'd0, prod, 32'd0};
        ST_XC3:   xc_q   <= xc_q + {prod, 64'd0};
        ST_XB0:   xb_q   <= {64'd0, prod};
        ST_XB1,
        ST_XB2:   xb_q   <= xb_q + {32'd0, prod, 32'd0};
        ST_XB3:   xb_q   <= xb_q + {prod, 64'd0};
        ST_RC:    rc_q   <= prod;
        ST_RB:    rb_q   <= prod;
        default:  ;
      endcase
    end
  end

  // Rank candidate against held best
  logic        better, com_lt;
  logic [17:0] cdd, bdd;

  always_comb begin
    com_lt = 1'b0;
    if (aspc_q != aspb_q) begin
      com_lt = aspc_q < aspb_q;
    end else if (cfg_i.refresh_wanted && (xc_q != xb_q)) begin
      com_lt = xc_q < xb_q;
    end else if (cand.w != held.w) begin
      com_lt = cand.w < held.w;
    end else if (cand.h != held.h) begin
      com_lt = cand.h < held.h;
    end else if (rc_q != rb_q) begin
      com_lt = rc_q < rb_q;
    end else if (cand.n != held.n) begin
      com_lt = cand.n < held.n;
    end else if (cand.d != held.d) begin
      com_lt = cand.d < held.d;
    end

    cdd = 18'(adiff16(cand.w, cfg_i.target_width)) + 18'(adiff16(cand.h, cfg_i.target_height));
    bdd = 18'(adiff16(held.w, cfg_i.target_width)) + 18'(adiff16(held.h, cfg_i.target_height));

    if (is_cover) begin
      if (ca_q != ba_q)    better = ca_q < ba_q;
      else if (cdd != bdd) better = cdd < bdd;
      else                 better = com_lt;
    end else begin
      if (ca_q != ba_q)    better = ca_q > ba_q;
      else                 better = com_lt;
    end
  end

  // Form updated bests and the report for a last request
  mode_t cov_d, sh_d;
  logic  have_cov_d, have_sh_d, cfg_ok;

  always_comb begin
    cov_d      = cov_q;
    sh_d       = sh_q;
    have_cov_d = have_cov_q;
    have_sh_d  = have_sh_q;
    if (cand_ok) begin
      if (is_cover) begin
        if (!have_cov_q || better) begin
          cov_d      = cand;
          have_cov_d = 1'b1;
        end
      end else if (!have_sh_q || better) begin
        sh_d      = cand;
        have_sh_d = 1'b1;
      end
    end

    cfg_ok = dim_ok(cfg_i.target_width) && dim_ok(cfg_i.target_height) &&
             (!cfg_i.refresh_wanted ||
              ((cfg_i.wanted_rate_num != 32'd0) && (cfg_i.wanted_rate_den != 32'd0)));

    res_o = '0;
    if (cfg_ok && have_cov_d) begin
      res_o = {1'b1, cov_d.w, cov_d.h, cov_d.n, cov_d.d};
    end else if (cfg_ok && have_sh_d) begin
      res_o = {1'b1, sh_d.w, sh_d.h, sh_d.n, sh_d.d};
    end
  end

  assign stat_o.last = item_q.last_mode;
  // out_busy is filled in at the top level
  assign stat_o.out_busy = 1'b0;

  // Commit bests, clear them at the end of a list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_cov_q <= 1'b0;
      have_sh_q  <= 1'b0;
      cov_q      <= '0;
      sh_q       <= '0;
    end else if (cmd_i.decide) begin
      if (item_q.last_mode) begin
        have_cov_q <= 1'b0;
        have_sh_q  <= 1'b0;
        cov_q      <= '0;
        sh_q       <= '0;
      end else begin
        have_cov_q <= have_cov_d;
        have_sh_q  <= have_sh_d;
        cov_q      <= cov_d;
        sh_q       <= sh_d;
      end
    end
  end

endmodule

// ===== rtl/display_mode_best_match_select.sv =====
// A registered result is produced for last requests only, after ranking and commit.
// A new request is accepted only once the previous one is through; 26 products pass one shared 32x32
// multiplier, then the ranking state ranks and commits, then the input reopens.
// A last request waits in the ranking state while an earlier result is stalled.
// Reset (rst_ni low, asynchronous) restores the register defaults and clears both bests.
module display_mode_best_match_select #(
  parameter int unsigned MAX_DIM = 16384
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  dmbms_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dmbms_pkg::out_t  out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);
  import dmbms_pkg::*;

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t dp_stat, stat;
  out_t  res, out_q;
  logic  out_valid_q;

  // Write configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_width    <= 16'd1920;
      cfg_q.target_height   <= 16'd1080;
      cfg_q.refresh_wanted  <= 1'b0;
      cfg_q.wanted_rate_num <= 32'd60;
      cfg_q.wanted_rate_den <= 32'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TARGET_WIDTH:    cfg_q.target_width    <= cfg_data_i[15:0];
        REG_TARGET_HEIGHT:   cfg_q.target_height   <= cfg_data_i[15:0];
        REG_REFRESH_WANTED:  cfg_q.refresh_wanted  <= cfg_data_i[0];
        REG_WANTED_RATE_NUM: cfg_q.wanted_rate_num <= cfg_data_i;
        REG_WANTED_RATE_DEN: cfg_q.wanted_rate_den <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    stat          = dp_stat;
    stat.out_busy = out_valid_q && out_stall_i;
  end

  dmbms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dmbms_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .cmd_i     (cmd),
    .stat_o    (dp_stat),
    .res_o     (res)
  );

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.decide && stat.last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.decide && stat.last) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A request enters only when the input is open
  a_load_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !in_stall_o) else $error("load while input stalled");

  // The product sequence starts right after a load
  a_load_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> cmd.calc && (cmd.step == ST_CWTH)) else $error("sequence did not start");

  // Ranking is never signalled twice in a row
  a_decide_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.decide |-> $past(cmd.decide) == 1'b0) else $error("double decide");

  // A last result never overwrites a stalled one
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.decide && stat.last) |-> !(out_valid_q && out_stall_i))
    else $error("result overrun");

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import dmbms_pkg::*;

  localparam int unsigned MAX_DIM = 16384;
  localparam int DRAIN_CYCLES = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_t        out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  // Shadow copy of the registers and of both running bests
  cfg_t  shadow_cfg;
  mode_t cover_best;
  mode_t short_best;
  bit    cover_held;
  bit    short_held;

  out_t  best_q[$];
  bit    failed;
  int    tx_idle_pct;
  int    rx_idle_pct;
  int    hold_left;

  display_mode_best_match_select u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic logic [63:0] abs_diff(logic [63:0] a, logic [63:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Sign of a*b - c*d at full width
  function automatic int prod_sign(logic [63:0] a, logic [63:0] b,
                                   logic [63:0] c, logic [63:0] d);
    logic [127:0] x;
    logic [127:0] y;
    x = 128'(a) * 128'(b);
    y = 128'(c) * 128'(d);
    if (x != y) return (x < y) ? -1 : 1;
    return 0;
  endfunction

  function automatic bit dim_in_range(logic [63:0] v);
    return (v != 0) && (v <= MAX_DIM);
  endfunction

  // Shared tie-break chain: aspect, refresh, size, rate, raw fields
  function automatic int tie_order(mode_t c, mode_t b);
    logic [63:0] tw, th, wn, wd;
    logic [63:0] can, cad, ban, bad, crn, crd, brn, brd;
    int r;
    tw  = 64'(shadow_cfg.target_width);
    th  = 64'(shadow_cfg.target_height);
    wn  = 64'(shadow_cfg.wanted_rate_num);
    wd  = 64'(shadow_cfg.wanted_rate_den);
    can = abs_diff(64'(c.w) * th, tw * 64'(c.h));
    cad = 64'(c.h) * th;
    ban = abs_diff(64'(b.w) * th, tw * 64'(b.h));
    bad = 64'(b.h) * th;
    r = prod_sign(can, bad, ban, cad);
    if (r != 0) return r;
    if (shadow_cfg.refresh_wanted) begin
      crn = abs_diff(64'(c.n) * wd, wn * 64'(c.d));
      crd = 64'(c.d) * wd;
      brn = abs_diff(64'(b.n) * wd, wn * 64'(b.d));
      brd = 64'(b.d) * wd;
      r = prod_sign(crn, brd, brn, crd);
      if (r != 0) return r;
    end
    if (c.w != b.w) return (c.w < b.w) ? -1 : 1;
    if (c.h != b.h) return (c.h < b.h) ? -1 : 1;
    r = prod_sign(64'(c.n), 64'(b.d), 64'(b.n), 64'(c.d));
    if (r != 0) return r;
    if (c.n != b.n) return (c.n < b.n) ? -1 : 1;
    if (c.d != b.d) return (c.d < b.d) ? -1 : 1;
    return 0;
  endfunction

  function automatic bit beats_cover(mode_t c, mode_t b);
    logic [63:0] ca, ba, cdd, bdd;
    ca  = 64'(c.w) * 64'(c.h);
    ba  = 64'(b.w) * 64'(b.h);
    if (ca != ba) return ca < ba;
    cdd = abs_diff(64'(c.w), 64'(shadow_cfg.target_width)) +
          abs_diff(64'(c.h), 64'(shadow_cfg.target_height));
    bdd = abs_diff(64'(b.w), 64'(shadow_cfg.target_width)) +
          abs_diff(64'(b.h), 64'(shadow_cfg.target_height));
    if (cdd != bdd) return cdd < bdd;
    return tie_order(c, b) < 0;
  endfunction

  function automatic bit beats_short(mode_t c, mode_t b);
    logic [63:0] ca, ba;
    ca = 64'(c.w) * 64'(c.h);
    ba = 64'(b.w) * 64'(b.h);
    if (ca != ba) return ca > ba;
    return tie_order(c, b) < 0;
  endfunction

  // Fold one accepted request into the bests; queue the pick on a last request
  function automatic void rank_mode(in_t it);
    mode_t c;
    out_t  r;
    bit    cfg_ok;
    c.w = it.mode_width;
    c.h = it.mode_height;
    c.n = it.mode_rate_num;
    c.d = it.mode_rate_den;
    if (it.verified && dim_in_range(64'(c.w)) && dim_in_range(64'(c.h)) &&
        c.n != 0 && c.d != 0) begin
      if (c.w >= shadow_cfg.target_width && c.h >= shadow_cfg.target_height) begin
        if (!cover_held || beats_cover(c, cover_best)) begin
          cover_best = c;
          cover_held = 1'b1;
        end
      end else begin
        if (!short_held || beats_short(c, short_best)) begin
          short_best = c;
          short_held = 1'b1;
        end
      end
    end
    if (!it.last_mode) return;
    cfg_ok = dim_in_range(64'(shadow_cfg.target_width)) &&
             dim_in_range(64'(shadow_cfg.target_height)) &&
             (!shadow_cfg.refresh_wanted ||
              (shadow_cfg.wanted_rate_num != 0 && shadow_cfg.wanted_rate_den != 0));
    r = '0;
    if (cfg_ok && (cover_held || short_held)) begin
      c = cover_held ? cover_best : short_best;
      r.found         = 1'b1;
      r.best_width    = c.w;
      r.best_height   = c.h;
      r.best_rate_num = c.n;
      r.best_rate_den = c.d;
    end
    best_q = {best_q, r};
    cover_best = '0;
    short_best = '0;
    cover_held = 1'b0;
    short_held = 1'b0;
  endfunction

  function automatic in_t make_mode(logic [15:0] w, logic [15:0] h, logic [31:0] n,
                                    logic [31:0] d, logic v, logic last);
    in_t it;
    it.mode_width    = w;
    it.mode_height   = h;
    it.mode_rate_num = n;
    it.mode_rate_den = d;
    it.verified      = v;
    it.last_mode     = last;
    return it;
  endfunction

  function automatic logic [15:0] pick_dim(bit is_w);
    logic [15:0] wl[6] = '{640, 1280, 1920, 2560, 3840, 16384};
    logic [15:0] hl[6] = '{480, 720, 1080, 1440, 2160, 16384};
    case ($urandom_range(11))
      0: return 16'd0;
      1: return 16'(MAX_DIM + 1);
      2: return 16'($urandom);
      3: return 16'($urandom_range(MAX_DIM, 1));
      4: return is_w ? shadow_cfg.target_width : shadow_cfg.target_height;
      default: return is_w ? wl[$urandom_range(5)] : hl[$urandom_range(5)];
    endcase
  endfunction

  function automatic logic [31:0] pick_rate(bit is_num);
    logic [31:0] nl[6] = '{60, 30, 50, 60000, 24000, 144};
    logic [31:0] dl[6] = '{1, 1001, 1000, 1, 2, 1};
    case ($urandom_range(11))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom;
      default: return is_num ? nl[$urandom_range(5)] : dl[$urandom_range(5)];
    endcase
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_mode(in_t it);
    if ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    do @(posedge clk_i); while (in_stall_o);
    rank_mode(it);
  endtask

  // Drop the request line and let the block drain
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (best_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_TARGET_WIDTH:    shadow_cfg.target_width    = val[15:0];
      REG_TARGET_HEIGHT:   shadow_cfg.target_height   = val[15:0];
      REG_REFRESH_WANTED:  shadow_cfg.refresh_wanted  = val[0];
      REG_WANTED_RATE_NUM: shadow_cfg.wanted_rate_num = val;
      REG_WANTED_RATE_DEN: shadow_cfg.wanted_rate_den = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_target(logic [15:0] w, logic [15:0] h, logic rw,
                            logic [31:0] n, logic [31:0] d);
    wait_idle();
    write_reg(REG_TARGET_WIDTH, {16'h0, w});
    write_reg(REG_TARGET_HEIGHT, {16'h0, h});
    write_reg(REG_REFRESH_WANTED, {31'h0, rw});
    write_reg(REG_WANTED_RATE_NUM, n);
    write_reg(REG_WANTED_RATE_DEN, d);
  endtask

  task automatic test_directed();
    // skipped entries, then a cover mode against a short one
    send_mode(make_mode(16'd0, 16'd1080, 32'd60, 32'd1, 1'b1, 1'b0));
    send_mode(make_mode(16'd1920, 16'd0, 32'd60, 32'd1, 1'b1, 1'b0));
    send_mode(make_mode(16'(MAX_DIM + 1), 16'd1080, 32'd60, 32'd1, 1'b1, 1'b0));
    send_mode(make_mode(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0));
    send_mode(make_mode(16'd1920, 16'd1080, 32'd0, 32'd1, 1'b1, 1'b0));
    send_mode(make_mode(16'd1920, 16'd1080, 32'd60, 32'd0, 1'b1, 1'b0));
    send_mode(make_mode(16'd2560, 16'd1440, 32'd60, 32'd1, 1'b0, 1'b0));
    send_mode(make_mode(16'd1280, 16'd720, 32'd60, 32'd1, 1'b1, 1'b0));
    send_mode(make_mode(16'd3840, 16'd2160, 32'd60, 32'd1, 1'b1, 1'b1));
    // only short modes, biggest wins
    send_mode(make_mode(16'd1280, 16'd720, 32'd30, 32'd1, 1'b1, 1'b0));
    send_mode(make_mode(16'd1600, 16'd900, 32'd60, 32'd1, 1'b1, 1'b1));
    // full tie: earlier entry stays
    send_mode(make_mode(16'(MAX_DIM), 16'(MAX_DIM), 32'd60, 32'd1, 1'b1, 1'b0));
    send_mode(make_mode(16'(MAX_DIM), 16'(MAX_DIM), 32'd60, 32'd1, 1'b1, 1'b1));
    // empty list
    send_mode(make_mode(16'd1, 16'd1, 32'd1, 32'd1, 1'b0, 1'b1));
    // refresh distance as tie-break
    set_target(16'd1920, 16'd1080, 1'b1, 32'd60000, 32'd1001);
    send_mode(make_mode(16'd1920, 16'd1080, 32'd50, 32'd1, 1'b1, 1'b0));
    send_mode(make_mode(16'd1920, 16'd1080, 32'd60, 32'd1, 1'b1, 1'b0));
    send_mode(make_mode(16'd1920, 16'd1080, 32'hFFFF_FFFF, 32'd1, 1'b1, 1'b1));
    // invalid config: zero wanted rate with refresh requested
    set_target(16'd1920, 16'd1080, 1'b1, 32'd0, 32'd1);
    send_mode(make_mode(16'd1920, 16'd1080, 32'd60, 32'd1, 1'b1, 1'b1));
    // config changed in the middle of a list
    set_target(16'd1, 16'd1, 1'b0, 32'd60, 32'd1);
    send_mode(make_mode(16'd800, 16'd600, 32'd60, 32'd1, 1'b1, 1'b0));
    set_target(16'(MAX_DIM), 16'(MAX_DIM), 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_mode(make_mode(16'd640, 16'd480, 32'd60, 32'd1, 1'b1, 1'b1));
    // invalid target width
    set_target(16'd0, 16'hFFFF, 1'b0, 32'd60, 32'd1);
    send_mode(make_mode(16'd640, 16'd480, 32'd60, 32'd1, 1'b1, 1'b1));
  endtask

  // Mostly well-formed lists with random content, some stray noise
  task automatic test_random(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(6, 1);
      for (int k = 0; k < len; k++) begin
        send_mode(make_mode(pick_dim(1'b1), pick_dim(1'b0), pick_rate(1'b1),
                            pick_rate(1'b0), ($urandom_range(9) != 0),
                            (k == len - 1) || ($urandom_range(19) == 0)));
        sent++;
      end
    end
  endtask

  task automatic test_config_sweep();
    set_target(16'($urandom), 16'($urandom), 1'b1, $urandom, $urandom);
    test_random(100);
    set_target(16'hFFFF, 16'h0001, 1'b1, 32'hFFFF_FFFF, 32'd0);
    test_random(40);
    set_target(16'd1, 16'(MAX_DIM), 1'b0, 32'd1, 32'hFFFF_FFFF);
    test_random(60);
    set_target(16'd1280, 16'd720, 1'b1, 32'd24000, 32'd1001);
    test_random(200);
  endtask

  // Receiver holds off while lists keep coming, so the input backs up
  task automatic test_backpressure();
    wait_idle();
    hold_left = 400;
    for (int k = 0; k < 30; k++)
      send_mode(make_mode(pick_dim(1'b1), pick_dim(1'b0), pick_rate(1'b1),
                          pick_rate(1'b0), 1'b1, 1'b1));
  endtask

  // Receiver stall, random or held off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i = 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left   = hold_left - 1;
    end else begin
      out_stall_i = ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Compare each delivered result with the oldest pick
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (best_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, out_data_o);
        failed = 1'b1;
      end else begin
        want = best_q.pop_front();
        if (out_data_o.found !== want.found ||
            out_data_o.best_width !== want.best_width ||
            out_data_o.best_height !== want.best_height ||
            out_data_o.best_rate_num !== want.best_rate_num ||
            out_data_o.best_rate_den !== want.best_rate_den) begin
          $display("%0t: mismatch, expected %h, actual %h", $realtime, want, out_data_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #40000000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_TARGET_WIDTH;
    cfg_data_i  = '0;
    failed      = 1'b0;
    hold_left   = 0;
    tx_idle_pct = 10;
    rx_idle_pct = 53;
    shadow_cfg.target_width    = 16'd1920;
    shadow_cfg.target_height   = 16'd1080;
    shadow_cfg.refresh_wanted  = 1'b0;
    shadow_cfg.wanted_rate_num = 32'd60;
    shadow_cfg.wanted_rate_den = 32'd1;
    cover_best = '0;
    short_best = '0;
    cover_held = 1'b0;
    short_held = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    set_target(16'd1920, 16'd1080, 1'b0, 32'd60, 32'd1);
    test_random(600);
    test_config_sweep();
    test_backpressure();
    tx_idle_pct = 53;
    rx_idle_pct = 10;
    set_target(16'd1920, 16'd1080, 1'b1, 32'd60, 32'd1);
    test_random(500);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_target(16'd2560, 16'd1440, 1'b0, 32'd144, 32'd1);
    test_random(500);

    wait_idle();
    if (!failed && best_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
